FILE: rtl/core/assert_macros.svh
// Assertion macros for the calculator block, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge out of reset.
`define ATDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds at a clock edge out of reset.
`define ATDC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ATDC_ASSERT(lbl, prop, msg)
`define ATDC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/core/atdc_pkg.sv
// Shared types and constants of the ASCII three-digit calculator.
`default_nettype none

package atdc_pkg;

  localparam int unsigned FRAME_LENGTH = 8;
  localparam int unsigned OPND_W       = 10;
  localparam int unsigned RES_W        = 21;
  localparam int unsigned DIGIT_W      = 4;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] OP_MUL     = 8'd42;
  localparam logic [7:0] OP_ADD     = 8'd43;
  localparam logic [7:0] OP_SUB     = 8'd45;
  localparam logic [7:0] OP_DIV     = 8'd47;

  // Positions within a frame
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_OP    = 3'd3;
  localparam logic [2:0] POS_LAST  = 3'(FRAME_LENGTH - 1);

  // Trial divisors of the decimal reduction: 1000 shifted up by ten, 100 and 10 by three
  localparam logic [RES_W-1:0] MOD_START  = RES_W'(1000 * 1024);
  localparam logic [RES_W-1:0] HUND_START = RES_W'(800);
  localparam logic [RES_W-1:0] TENS_START = RES_W'(80);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_NEGATIVE   = 3'd2,
    ST_DIV_ZERO   = 3'd3,
    ST_BAD_DIGIT  = 3'd4,
    ST_UNKNOWN_OP = 3'd5
  } status_e;

  typedef struct packed {
    logic [OPND_W-1:0] opa;
    logic [OPND_W-1:0] opb;
    logic [7:0]        op;
    logic              derr;
  } frame_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    status_e            status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/atdc_if.sv
// Valid/ready channel interfaces for received bytes and result digits.
`default_nettype none

interface atdc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atdc_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_digit;
  logic [2:0] status;

  modport source (output valid, output tx_byte, output last_digit, output status, input ready);
  modport sink   (input valid, input tx_byte, input last_digit, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ascii_three_digit_calculator.sv
// Top level of the ASCII three-digit calculator: frame capture, sequencer and digit sender.
//
//  channel  | dir | payload                          | transaction
//  ---------+-----+----------------------------------+---------------------------------
//  rx_i     | in  | rx_byte[7:0]                     | one frame byte
//  tx_o     | out | tx_byte[7:0], last_digit, status | one ASCII result digit
//
// Bytes one to seven of a frame are only stored and produce nothing.
// The terminator starts the sequencer around the single shared adder:
//   multiply, divide or add/subtract (skipped for divide by zero or an
//   unknown operator), then sign, reduction modulo a thousand, hundreds,
//   tens and a finishing state before the first digit.
// rx_i.ready stays low while the sequencer runs, and a terminator is held off
//   until the previous three digits have all gone; other bytes pass meanwhile.
// Reset (rst_ni low, asynchronous) clears frame position, operands and the
//   kept result; the first byte after reset starts a new frame.
`default_nettype none
`include "assert_macros.svh"

module ascii_three_digit_calculator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  atdc_rx_if.sink    rx_i,
  atdc_tx_if.source  tx_o
);

  atdc_pkg::frame_t  frame;
  atdc_pkg::result_t result;
  logic              frame_term;
  logic              rx_accept;
  logic              calc_busy;
  logic              calc_done;

  // Hold every byte while a calculation runs, and the terminator while digits still wait to go
  assign rx_i.ready = !calc_busy && (!frame_term || !tx_o.valid);
  assign rx_accept  = rx_i.valid && rx_i.ready;

  atdc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_i.rx_byte),
    .frame_o   (frame),
    .term_o    (frame_term)
  );

  // Start on the accepted terminator; the stored operands are already complete
  atdc_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rx_accept && frame_term),
    .frame_i  (frame),
    .busy_o   (calc_busy),
    .done_o   (calc_done),
    .result_o (result)
  );

  // Load the digit buffer as the sequencer finishes; it is empty by construction
  atdc_tx u_tx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (calc_done),
    .result_i (result),
    .tx_o     (tx_o)
  );

  `ATDC_ASSERT_NEVER(a_busy_while_sending, calc_busy && tx_o.valid, "calc ran while digits pending")
  `ATDC_ASSERT(a_term_starts_calc, (rx_accept && frame_term) |=> calc_busy, "calc not started")
  `ATDC_ASSERT(a_last_ends_run, (tx_o.valid && tx_o.ready && tx_o.last_digit) |=> !tx_o.valid, "digits after last")

endmodule

`default_nettype wire

FILE: rtl/core/atdc_frame.sv
// Frame capture: byte position, operand accumulation, operator and bad-digit flag.
`default_nettype none

module atdc_frame (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  output atdc_pkg::frame_t     frame_o,
  output logic                 term_o
);

  logic [2:0]       pos_q, pos_d;
  atdc_pkg::frame_t frm_q, frm_d;

  logic                          digit_ok;
  logic [7:0]                    digit_raw;
  logic [atdc_pkg::DIGIT_W-1:0]  digit;
  logic [atdc_pkg::OPND_W-1:0]   base_a;
  logic                          base_err;

  // acc * 10 + d, kept to the operand width
  function automatic logic [atdc_pkg::OPND_W-1:0] take_digit(
    input logic [atdc_pkg::OPND_W-1:0]  acc,
    input logic [atdc_pkg::DIGIT_W-1:0] d
  );
    logic [atdc_pkg::OPND_W+3:0] t;
    t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, d};
    return t[atdc_pkg::OPND_W-1:0];
  endfunction

  always_comb begin
    digit_ok  = (rx_byte_i >= atdc_pkg::ASCII_ZERO) && (rx_byte_i <= atdc_pkg::ASCII_NINE);
    digit_raw = rx_byte_i - atdc_pkg::ASCII_ZERO;
    digit     = digit_ok ? digit_raw[atdc_pkg::DIGIT_W-1:0] : '0;
    base_a    = (pos_q == atdc_pkg::POS_FIRST) ? '0 : frm_q.opa;
    base_err  = (pos_q == atdc_pkg::POS_FIRST) ? 1'b0 : frm_q.derr;

    pos_d = pos_q;
    frm_d = frm_q;
    if (accept_i) begin
      if (pos_q == atdc_pkg::POS_LAST) begin
        pos_d = atdc_pkg::POS_FIRST;
      end else begin
        pos_d = pos_q + 3'd1;
        if (pos_q == atdc_pkg::POS_FIRST) begin
          frm_d.opb = '0;
        end
        if (pos_q < atdc_pkg::POS_OP) begin
          frm_d.opa  = take_digit(base_a, digit);
          frm_d.derr = base_err | ~digit_ok;
        end else if (pos_q == atdc_pkg::POS_OP) begin
          frm_d.op = rx_byte_i;
        end else begin
          frm_d.opb  = take_digit(frm_q.opb, digit);
          frm_d.derr = frm_q.derr | ~digit_ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= atdc_pkg::POS_FIRST;
      frm_q <= '0;
    end else begin
      pos_q <= pos_d;
      frm_q <= frm_d;
    end
  end

  assign frame_o = frm_q;
  assign term_o  = (pos_q == atdc_pkg::POS_LAST);

endmodule

`default_nettype wire

FILE: rtl/core/atdc_alu.sv
// Shared adder/subtractor with carry out; carry set on subtract means a >= b.
`default_nettype none

module atdc_alu (
  input  wire logic [atdc_pkg::RES_W-1:0] a_i,
  input  wire logic [atdc_pkg::RES_W-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [atdc_pkg::RES_W-1:0] y_o,
  output logic                            carry_o
);

  logic [atdc_pkg::RES_W:0] sum;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i ^ {atdc_pkg::RES_W{sub_i}}} +
          {{atdc_pkg::RES_W{1'b0}}, sub_i};
  end

  assign y_o     = sum[atdc_pkg::RES_W-1:0];
  assign carry_o = sum[atdc_pkg::RES_W];

endmodule

`default_nettype wire

FILE: rtl/core/atdc_calc.sv
// Sequencer around the shared adder: multiply, divide, add, subtract, sign and decimal digits.
`default_nettype none

module atdc_calc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire atdc_pkg::frame_t  frame_i,
  output logic                   busy_o,
  output logic                   done_o,
  output atdc_pkg::result_t      result_o
);

  localparam int unsigned RW = atdc_pkg::RES_W;
  localparam int unsigned OW = atdc_pkg::OPND_W;
  localparam logic [3:0] BIT_LAST   = 4'(OW - 1);
  localparam logic [3:0] MOD_LAST   = 4'd10;
  localparam logic [3:0] DIGIT_LAST = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_ADDSUB, S_SIGN, S_MOD, S_HUND, S_TENS, S_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [OW-1:0]  opa_q, opa_d, opb_q, opb_d;
  logic [7:0]     op_q, op_d;
  logic           derr_q, derr_d, unk_q, unk_d, dz_q, dz_d;
  logic           neg_q, neg_d, ovf_q, ovf_d;
  logic [RW-1:0]  acc_q, acc_d, work_q, work_d, res_q, res_d;
  logic [3:0]     cnt_q, cnt_d;
  logic [atdc_pkg::DIGIT_W-1:0] hund_q, hund_d, tens_q, tens_d;

  logic [RW-1:0]  alu_a, alu_b, alu_y;
  logic           alu_sub, alu_c;
  logic [OW:0]    trial;
  atdc_pkg::status_e status;

  atdc_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .y_o     (alu_y),
    .carry_o (alu_c)
  );

  // Operand selection for the shared unit
  always_comb begin
    trial   = {acc_q[OW-1:0], work_q[OW-1]};
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        alu_a = {acc_q[RW-2:0], 1'b0};
        alu_b = work_q[OW-1] ? {{(RW-OW){1'b0}}, opa_q} : '0;
      end
      S_DIV: begin
        alu_a   = {{(RW-OW-1){1'b0}}, trial};
        alu_b   = {{(RW-OW){1'b0}}, opb_q};
        alu_sub = 1'b1;
      end
      S_ADDSUB: begin
        alu_a   = {{(RW-OW){1'b0}}, opa_q};
        alu_b   = {{(RW-OW){1'b0}}, opb_q};
        alu_sub = (op_q == atdc_pkg::OP_SUB);
      end
      S_SIGN: begin
        alu_b   = res_q;
        alu_sub = 1'b1;
      end
      S_MOD, S_HUND, S_TENS: begin
        alu_a   = work_q;
        alu_b   = acc_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    if (unk_q)       status = atdc_pkg::ST_UNKNOWN_OP;
    else if (derr_q) status = atdc_pkg::ST_BAD_DIGIT;
    else if (dz_q)   status = atdc_pkg::ST_DIV_ZERO;
    else if (neg_q)  status = atdc_pkg::ST_NEGATIVE;
    else if (ovf_q)  status = atdc_pkg::ST_OVERFLOW;
    else             status = atdc_pkg::ST_OK;
  end

  always_comb begin
    state_d = state_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    op_d    = op_q;
    derr_d  = derr_q;
    unk_d   = unk_q;
    dz_d    = dz_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    acc_d   = acc_q;
    work_d  = work_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    hund_d  = hund_q;
    tens_d  = tens_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          opa_d  = frame_i.opa;
          opb_d  = frame_i.opb;
          op_d   = frame_i.op;
          derr_d = frame_i.derr;
          unk_d  = 1'b0;
          dz_d   = 1'b0;
          acc_d  = '0;
          cnt_d  = BIT_LAST;
          case (frame_i.op)
            atdc_pkg::OP_MUL: begin
              work_d  = {{(RW-OW){1'b0}}, frame_i.opb};
              state_d = S_MUL;
            end
            atdc_pkg::OP_ADD, atdc_pkg::OP_SUB: begin
              state_d = S_ADDSUB;
            end
            atdc_pkg::OP_DIV: begin
              if (frame_i.opb == '0) begin
                res_d   = '0;
                dz_d    = 1'b1;
                state_d = S_SIGN;
              end else begin
                work_d  = {{(RW-OW){1'b0}}, frame_i.opa};
                state_d = S_DIV;
              end
            end
            default: begin
              unk_d   = 1'b1;
              state_d = S_SIGN;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_d  = alu_y;
        work_d = {work_q[RW-2:0], 1'b0};
        if (cnt_q == '0) begin
          res_d   = alu_y;
          state_d = S_SIGN;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_DIV: begin
        acc_d  = alu_c ? alu_y : {{(RW-OW-1){1'b0}}, trial};
        work_d = {work_q[RW-2:0], alu_c};
        if (cnt_q == '0) begin
          res_d   = {{(RW-OW){1'b0}}, work_q[OW-2:0], alu_c};
          state_d = S_SIGN;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_ADDSUB: begin
        res_d   = alu_y;
        state_d = S_SIGN;
      end
      S_SIGN: begin
        // Take the magnitude of the two's complement result
        neg_d   = res_q[RW-1];
        work_d  = res_q[RW-1] ? alu_y : res_q;
        ovf_d   = 1'b0;
        acc_d   = atdc_pkg::MOD_START;
        cnt_d   = MOD_LAST;
        state_d = S_MOD;
      end
      S_MOD: begin
        // Any successful trial subtraction means the magnitude reaches a thousand
        if (alu_c) begin
          work_d = alu_y;
          ovf_d  = 1'b1;
        end
        acc_d = acc_q >> 1;
        if (cnt_q == '0) begin
          acc_d   = atdc_pkg::HUND_START;
          cnt_d   = DIGIT_LAST;
          state_d = S_HUND;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_HUND: begin
        if (alu_c) work_d = alu_y;
        hund_d[cnt_q[1:0]] = alu_c;
        acc_d = acc_q >> 1;
        if (cnt_q == '0) begin
          acc_d   = atdc_pkg::TENS_START;
          cnt_d   = DIGIT_LAST;
          state_d = S_TENS;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_TENS: begin
        if (alu_c) work_d = alu_y;
        tens_d[cnt_q[1:0]] = alu_c;
        acc_d = acc_q >> 1;
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      opa_q   <= '0;
      opb_q   <= '0;
      op_q    <= '0;
      derr_q  <= 1'b0;
      unk_q   <= 1'b0;
      dz_q    <= 1'b0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      acc_q   <= '0;
      work_q  <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
      hund_q  <= '0;
      tens_q  <= '0;
    end else begin
      state_q <= state_d;
      opa_q   <= opa_d;
      opb_q   <= opb_d;
      op_q    <= op_d;
      derr_q  <= derr_d;
      unk_q   <= unk_d;
      dz_q    <= dz_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      acc_q   <= acc_d;
      work_q  <= work_d;
      res_q   <= res_d;
      cnt_q   <= cnt_d;
      hund_q  <= hund_d;
      tens_q  <= tens_d;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_FINISH);
  assign result_o.hund   = hund_q;
  assign result_o.tens   = tens_q;
  assign result_o.ones   = work_q[atdc_pkg::DIGIT_W-1:0];
  assign result_o.status = status;

endmodule

`default_nettype wire

FILE: rtl/core/atdc_tx.sv
// Output buffer: holds the three result digits and sends them hundreds first.
`default_nettype none

module atdc_tx (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire atdc_pkg::result_t  result_i,
  atdc_tx_if.source               tx_o
);

  localparam logic [1:0] IDX_HUND = 2'd0;
  localparam logic [1:0] IDX_TENS = 2'd1;
  localparam logic [1:0] IDX_ONES = 2'd2;

  atdc_pkg::result_t            res_q;
  logic                         valid_q;
  logic [1:0]                   idx_q;
  logic [atdc_pkg::DIGIT_W-1:0] digit;

  always_comb begin
    case (idx_q)
      IDX_HUND: digit = res_q.hund;
      IDX_TENS: digit = res_q.tens;
      default:  digit = res_q.ones;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= IDX_HUND;
      res_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= IDX_HUND;
      res_q   <= result_i;
    end else if (valid_q && tx_o.ready) begin
      if (idx_q == IDX_ONES) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assign tx_o.valid      = valid_q;
  assign tx_o.tx_byte    = atdc_pkg::ASCII_ZERO + {4'b0, digit};
  assign tx_o.last_digit = (idx_q == IDX_ONES);
  assign tx_o.status     = res_q.status;

endmodule

`default_nettype wire
